/* hdl/tsb_pkg.sv */
// Shared types and codes for the bilinear texture sampler.
`timescale 1ns / 1ps
`default_nettype none
package tsb_pkg;

   localparam logic FUNC_LOAD   = 1'b0;
   localparam logic FUNC_SAMPLE = 1'b1;

   localparam logic [1:0] EDGE_CLAMP     = 2'd0;
   localparam logic [1:0] EDGE_REPEAT    = 2'd1;
   localparam logic [1:0] EDGE_UNCHECKED = 2'd2;

   localparam logic [2:0] REG_TEX_WIDTH      = 3'd0;
   localparam logic [2:0] REG_TEX_HEIGHT     = 3'd1;
   localparam logic [2:0] REG_EDGE_MODE      = 3'd2;
   localparam logic [2:0] REG_FILTER_LINEAR  = 3'd3;
   localparam logic [2:0] REG_SOURCE_ALPHA   = 3'd4;
   localparam logic [2:0] REG_ALPHA_MODULATE = 3'd5;
   localparam logic [2:0] REG_CONST_ALPHA    = 3'd6;

   // coordinate reduction stages
   typedef struct packed {
      logic        v;
      logic        func;
      logic [15:0] addr;
      logic [31:0] data;
      logic [15:0] x;
      logic [15:0] y;
      logic [7:0]  fx;
      logic [15:0] fy;
      logic [15:0] ax;
      logic [15:0] ay;
      logic [8:0]  rx;
      logic [8:0]  ry;
      logic [8:0]  w;
      logic [8:0]  h;
   } crd_type;

   typedef struct packed {
      logic        v;
      logic        func;
      logic [15:0] addr;
      logic [31:0] data;
      logic [7:0]  fx;
      logic [15:0] fy;
      logic [15:0] x0;
      logic [15:0] x1;
      logic [15:0] y0;
      logic [15:0] y1;
   } nbr_type;

   typedef struct packed {
      logic        v;
      logic        func;
      logic [15:0] addr;
      logic [31:0] data;
      logic [7:0]  fx;
      logic [15:0] fy;
      logic [15:0] a00;
      logic [15:0] a01;
      logic [15:0] a10;
      logic [15:0] a11;
   } adr_type;

endpackage
`default_nettype wire

/* hdl/texture_sampler_bilinear_edge.sv */
// Top level: pipelined bilinear texture sampler with edge handling.
`timescale 1ns / 1ps
`default_nettype none
// One beat in per clock, loads and samples alike, and a stall on rsp holds
// the whole pipe. A sample's result passes the modulo, neighbour, address,
// read, blend and output registers. Repeat-mode modulo runs as a four-stage
// restoring divider, four bits a stage. The store is kept as four copies so
// the four neighbours of a bilinear tap are read in the same cycle; loads
// write all copies in the read stage, so samples always see loads in beat
// order. Nearest mode runs the same blend with zero fractions.
module texture_sampler_bilinear_edge #(
   parameter int ROW_STRIDE = 256,
   parameter int MAX_ROWS   = 256
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // texel_addr[15:0], texel_data[47:16], pos_x[79:48], pos_y[111:80]
   input  wire logic [111:0] req_tdata,
   // func[0]
   input  wire logic         req_tuser,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // red[7:0], green[15:8], blue[23:16], alpha[31:24]
   output logic [31:0]       rsp_tdata,
   input  wire logic         csr_we,
   input  wire logic [2:0]   csr_addr,
   input  wire logic [8:0]   csr_wdata
);

   localparam logic [15:0] STRIDE = 16'(ROW_STRIDE);

   logic [8:0] tex_width_ff, tex_height_ff;
   logic [1:0] edge_mode_ff;
   logic       filter_linear_ff, source_alpha_ff, alpha_modulate_ff;
   logic [7:0] const_alpha_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tex_width_ff      <= 9'd256;
         tex_height_ff     <= 9'd256;
         edge_mode_ff      <= tsb_pkg::EDGE_CLAMP;
         filter_linear_ff  <= 1'b0;
         source_alpha_ff   <= 1'b1;
         alpha_modulate_ff <= 1'b0;
         const_alpha_ff    <= 8'd255;
      end else if (csr_we) begin
         unique case (csr_addr)
            tsb_pkg::REG_TEX_WIDTH:      tex_width_ff      <= csr_wdata;
            tsb_pkg::REG_TEX_HEIGHT:     tex_height_ff     <= csr_wdata;
            tsb_pkg::REG_EDGE_MODE:      edge_mode_ff      <= csr_wdata[1:0];
            tsb_pkg::REG_FILTER_LINEAR:  filter_linear_ff  <= csr_wdata[0];
            tsb_pkg::REG_SOURCE_ALPHA:   source_alpha_ff   <= csr_wdata[0];
            tsb_pkg::REG_ALPHA_MODULATE: alpha_modulate_ff <= csr_wdata[0];
            tsb_pkg::REG_CONST_ALPHA:    const_alpha_ff    <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   logic en;
   logic out_v_ff;
   assign en         = !out_v_ff || rsp_tready;
   assign req_tready = en;

   function automatic logic [8:0] mod_step(input logic [8:0] r, input logic b,
                                           input logic [8:0] d);
      logic [9:0] t;
      t = {r, b};
      if (t >= {1'b0, d}) t = t - {1'b0, d};
      return t[8:0];
   endfunction

   // entry: effective size and magnitudes
   logic [8:0]  w_eff, h_eff;
   logic [15:0] in_x, in_y;
   tsb_pkg::crd_type md_in [5];
   tsb_pkg::crd_type md_ff [5];

   always_comb begin
      if (tex_width_ff == 9'd0) w_eff = 9'd1;
      else if ({23'd0, tex_width_ff} > 32'(ROW_STRIDE)) w_eff = 9'(ROW_STRIDE);
      else w_eff = tex_width_ff;
      if (tex_height_ff == 9'd0) h_eff = 9'd1;
      else if ({23'd0, tex_height_ff} > 32'(MAX_ROWS)) h_eff = 9'(MAX_ROWS);
      else h_eff = tex_height_ff;
      in_x = req_tdata[79:64];
      in_y = req_tdata[111:96];
      md_in[0].v    = req_tvalid;
      md_in[0].func = req_tuser;
      md_in[0].addr = req_tdata[15:0];
      md_in[0].data = req_tdata[47:16];
      md_in[0].x    = in_x;
      md_in[0].y    = in_y;
      md_in[0].fx   = filter_linear_ff ? req_tdata[63:56] : 8'd0;
      md_in[0].fy   = filter_linear_ff ? req_tdata[95:80] : 16'd0;
      md_in[0].ax   = in_x[15] ? (~in_x + 16'd1) : in_x;
      md_in[0].ay   = in_y[15] ? (~in_y + 16'd1) : in_y;
      md_in[0].rx   = 9'd0;
      md_in[0].ry   = 9'd0;
      md_in[0].w    = w_eff;
      md_in[0].h    = h_eff;
      for (int i = 1; i < 5; i++) begin
         md_in[i] = md_ff[i-1];
         for (int j = 0; j < 4; j++) begin
            md_in[i].rx = mod_step(md_in[i].rx, md_ff[i-1].ax[19 - 4*i - j],
                                   md_ff[i-1].w);
            md_in[i].ry = mod_step(md_in[i].ry, md_ff[i-1].ay[19 - 4*i - j],
                                   md_ff[i-1].h);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 5; i++) md_ff[i].v <= 1'b0;
      end else if (en) begin
         for (int i = 0; i < 5; i++) md_ff[i] <= md_in[i];
      end
   end

   // neighbour coordinates per edge mode
   tsb_pkg::crd_type md;
   tsb_pkg::nbr_type nb_in, nb_ff;
   logic [8:0] rxf, ryf, wm1, hm1, rx1, ry1;

   always_comb begin
      md  = md_ff[4];
      rxf = (md.x[15] && md.rx != 9'd0) ? md.w - md.rx : md.rx;
      ryf = (md.y[15] && md.ry != 9'd0) ? md.h - md.ry : md.ry;
      rx1 = (rxf + 9'd1 == md.w) ? 9'd0 : rxf + 9'd1;
      ry1 = (ryf + 9'd1 == md.h) ? 9'd0 : ryf + 9'd1;
      wm1 = md.w - 9'd1;
      hm1 = md.h - 9'd1;
      nb_in.v    = md.v;
      nb_in.func = md.func;
      nb_in.addr = md.addr;
      nb_in.data = md.data;
      nb_in.fx   = md.fx;
      nb_in.fy   = md.fy;
      case (edge_mode_ff)
         tsb_pkg::EDGE_REPEAT: begin
            nb_in.x0 = {7'd0, rxf};
            nb_in.x1 = {7'd0, rx1};
            nb_in.y0 = {7'd0, ryf};
            nb_in.y1 = {7'd0, ry1};
         end
         tsb_pkg::EDGE_UNCHECKED: begin
            nb_in.x0 = md.x;
            nb_in.x1 = md.x + 16'd1;
            nb_in.y0 = md.y;
            nb_in.y1 = md.y + 16'd1;
         end
         default: begin
            if (md.x[15]) begin
               nb_in.x0 = 16'd0;
               nb_in.x1 = 16'd0;
            end else if (md.x >= {7'd0, wm1}) begin
               nb_in.x0 = {7'd0, wm1};
               nb_in.x1 = {7'd0, wm1};
            end else begin
               nb_in.x0 = md.x;
               nb_in.x1 = md.x + 16'd1;
            end
            if (md.y[15]) begin
               nb_in.y0 = 16'd0;
               nb_in.y1 = 16'd0;
            end else if (md.y >= {7'd0, hm1}) begin
               nb_in.y0 = {7'd0, hm1};
               nb_in.y1 = {7'd0, hm1};
            end else begin
               nb_in.y0 = md.y;
               nb_in.y1 = md.y + 16'd1;
            end
         end
      endcase
   end

   // texel addresses
   tsb_pkg::adr_type ad_in, ad_ff;
   logic [15:0] row0, row1;

   always_comb begin
      row0 = 16'(nb_ff.y0 * STRIDE);
      row1 = 16'(nb_ff.y1 * STRIDE);
      ad_in.v    = nb_ff.v;
      ad_in.func = nb_ff.func;
      ad_in.addr = nb_ff.addr;
      ad_in.data = nb_ff.data;
      ad_in.fx   = nb_ff.fx;
      ad_in.fy   = nb_ff.fy;
      ad_in.a00  = row0 + nb_ff.x0;
      ad_in.a01  = row0 + nb_ff.x1;
      ad_in.a10  = row1 + nb_ff.x0;
      ad_in.a11  = row1 + nb_ff.x1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         nb_ff.v <= 1'b0;
         ad_ff.v <= 1'b0;
      end else if (en) begin
         nb_ff <= nb_in;
         ad_ff <= ad_in;
      end
   end

   // texture store, one copy per neighbour
   logic [31:0] mem0 [65536];
   logic [31:0] mem1 [65536];
   logic [31:0] mem2 [65536];
   logic [31:0] mem3 [65536];
   logic [31:0] t0_ff, t1_ff, t2_ff, t3_ff;
   logic        rd_v_ff, rd_func_ff;
   logic [7:0]  rd_fx_ff;
   logic [15:0] rd_fy_ff;
   logic        wr_en;

   assign wr_en = en && ad_ff.v && ad_ff.func == tsb_pkg::FUNC_LOAD;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem0[ad_ff.addr] <= ad_ff.data;
         mem1[ad_ff.addr] <= ad_ff.data;
         mem2[ad_ff.addr] <= ad_ff.data;
         mem3[ad_ff.addr] <= ad_ff.data;
      end
      if (en) begin
         t0_ff <= mem0[ad_ff.a00];
         t1_ff <= mem1[ad_ff.a01];
         t2_ff <= mem2[ad_ff.a10];
         t3_ff <= mem3[ad_ff.a11];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_v_ff <= 1'b0;
      end else if (en) begin
         rd_v_ff    <= ad_ff.v;
         rd_func_ff <= ad_ff.func;
         rd_fx_ff   <= ad_ff.fx;
         rd_fy_ff   <= ad_ff.fy;
      end
   end

   // horizontal blend
   logic [31:0] q0, q1, q2, q3;
   logic [8:0]  fnx;
   logic [15:0] top_in [4];
   logic [15:0] bot_in [4];
   logic [15:0] top_ff [4];
   logic [15:0] bot_ff [4];
   logic        hb_v_ff, hb_func_ff;
   logic [15:0] hb_fy_ff;

   always_comb begin
      q0  = source_alpha_ff ? t0_ff : {8'hff, t0_ff[23:0]};
      q1  = source_alpha_ff ? t1_ff : {8'hff, t1_ff[23:0]};
      q2  = source_alpha_ff ? t2_ff : {8'hff, t2_ff[23:0]};
      q3  = source_alpha_ff ? t3_ff : {8'hff, t3_ff[23:0]};
      fnx = 9'd256 - {1'b0, rd_fx_ff};
      for (int k = 0; k < 4; k++) begin
         top_in[k] = 16'(q0[8*k +: 8] * fnx) + 16'(q1[8*k +: 8] * rd_fx_ff);
         bot_in[k] = 16'(q2[8*k +: 8] * fnx) + 16'(q3[8*k +: 8] * rd_fx_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hb_v_ff <= 1'b0;
      end else if (en) begin
         top_ff     <= top_in;
         bot_ff     <= bot_in;
         hb_v_ff    <= rd_v_ff;
         hb_func_ff <= rd_func_ff;
         hb_fy_ff   <= rd_fy_ff;
      end
   end

   // vertical blend, >> 24
   logic [16:0] fny;
   logic [32:0] vsum [4];
   logic [7:0]  ch_ff [4];
   logic        vb_v_ff;

   always_comb begin
      fny = 17'h10000 - {1'b0, hb_fy_ff};
      for (int k = 0; k < 4; k++) begin
         vsum[k] = 33'(top_ff[k] * fny) + 33'(bot_ff[k] * hb_fy_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vb_v_ff <= 1'b0;
      end else if (en) begin
         for (int k = 0; k < 4; k++) ch_ff[k] <= vsum[k][31:24];
         vb_v_ff <= hb_v_ff && hb_func_ff == tsb_pkg::FUNC_SAMPLE;
      end
   end

   // alpha modulation and output register
   logic [15:0] amul;
   logic [7:0]  alpha_in;
   logic [31:0] out_ff;

   always_comb begin
      amul = ch_ff[3] * const_alpha_ff;
      if (!alpha_modulate_ff) alpha_in = ch_ff[3];
      else if (source_alpha_ff) alpha_in = amul[15:8];
      else alpha_in = const_alpha_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (en) begin
         out_v_ff <= vb_v_ff;
         out_ff   <= {alpha_in, ch_ff[0], ch_ff[1], ch_ff[2]};
      end
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = out_ff;

   a_load_no_rsp: assert property (@(posedge clock) disable iff (reset)
      (en && hb_v_ff && hb_func_ff == tsb_pkg::FUNC_LOAD) |=> !vb_v_ff)
      else $error("load beat produced a result");

   a_mod_range: assert property (@(posedge clock) disable iff (reset)
      md_ff[4].v |-> (md_ff[4].rx < md_ff[4].w && md_ff[4].ry < md_ff[4].h))
      else $error("modulo remainder out of range");

   a_coord_range: assert property (@(posedge clock) disable iff (reset)
      (md_ff[4].v && en && edge_mode_ff != tsb_pkg::EDGE_UNCHECKED)
      |=> (nb_ff.x0 < {7'd0, $past(md_ff[4].w)}
           && nb_ff.y0 < {7'd0, $past(md_ff[4].h)}))
      else $error("edge-handled coordinate outside texture");

endmodule
`default_nettype wire

/* bench/tsb_checker.sv */
// Checker for the texture sampler: predicts each sample beat and compares rsp beats.
`timescale 1ns / 1ps
`default_nettype none
module tsb_checker (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   input  wire logic         req_tready,
   input  wire logic [111:0] req_tdata,
   input  wire logic         req_tuser,
   input  wire logic         rsp_tvalid,
   input  wire logic         rsp_tready,
   input  wire logic [31:0]  rsp_tdata,
   input  wire logic         csr_we,
   input  wire logic [2:0]   csr_addr,
   input  wire logic [8:0]   csr_wdata,
   output int                errors,
   output int                pending
);

   logic [31:0] texels [0:65535];
   logic [31:0] pixel_q [$];

   logic [8:0] tex_w, tex_h;
   logic [1:0] edge_sel;
   logic       linear, has_alpha, modulate;
   logic [7:0] alpha_k;

   function automatic int pmod(int v, int n);
      int r;
      r = v % n;
      return (r < 0) ? r + n : r;
   endfunction

   function automatic logic [15:0] addr_of(int x, int y);
      logic [31:0] s;
      s = y * 256 + x;
      return s[15:0];
   endfunction

   function automatic logic [31:0] texel_at(logic [15:0] a);
      logic [31:0] t;
      t = texels[a];
      if (!has_alpha) t[31:24] = 8'hff;
      return t;
   endfunction

   // returns {alpha, blue, green, red}
   function automatic logic [31:0] sample_pixel(logic [31:0] px, logic [31:0] py);
      int x, y, w, h, xs, ys;
      logic [15:0] a [4];
      logic [31:0] t [4];
      longint fx, fnx, fy, fny, top, bot, sum;
      logic [7:0] ch [4];
      logic [15:0] prod;
      x = $signed(px[31:16]);
      y = $signed(py[31:16]);
      w = tex_w; h = tex_h;
      if (w < 1) w = 1;
      if (w > 256) w = 256;
      if (h < 1) h = 1;
      if (h > 256) h = 256;
      if (linear) begin
         fx = px[15:8]; fnx = 256 - fx;
         fy = py[15:0]; fny = 65536 - fy;
         if (edge_sel == tsb_pkg::EDGE_UNCHECKED) begin
            a[0] = addr_of(x, y);
            a[1] = a[0] + 16'd1;
            a[2] = a[0] + 16'd256;
            a[3] = a[2] + 16'd1;
         end else if (edge_sel == tsb_pkg::EDGE_REPEAT) begin
            a[0] = addr_of(pmod(x, w), pmod(y, h));
            a[1] = addr_of(pmod(x + 1, w), pmod(y, h));
            a[2] = addr_of(pmod(x, w), pmod(y + 1, h));
            a[3] = addr_of(pmod(x + 1, w), pmod(y + 1, h));
         end else begin
            xs = 1; ys = 1;
            if (x < 0) begin x = 0; xs = 0; end
            else if (x >= w - 1) begin x = w - 1; xs = 0; end
            if (y < 0) begin y = 0; ys = 0; end
            else if (y >= h - 1) begin y = h - 1; ys = 0; end
            a[0] = addr_of(x, y);
            a[1] = addr_of(x + xs, y);
            a[2] = addr_of(x, y + ys);
            a[3] = addr_of(x + xs, y + ys);
         end
         for (int i = 0; i < 4; i++) t[i] = texel_at(a[i]);
         for (int k = 0; k < 4; k++) begin
            top = longint'(t[0][8*k +: 8]) * fnx + longint'(t[1][8*k +: 8]) * fx;
            bot = longint'(t[2][8*k +: 8]) * fnx + longint'(t[3][8*k +: 8]) * fx;
            sum = (top * fny + bot * fy) >>> 24;
            ch[k] = sum[7:0];
         end
      end else begin
         if (edge_sel == tsb_pkg::EDGE_REPEAT) begin
            x = pmod(x, w);
            y = pmod(y, h);
         end else if (edge_sel != tsb_pkg::EDGE_UNCHECKED) begin
            if (x < 0) x = 0;
            else if (x >= w) x = w - 1;
            if (y < 0) y = 0;
            else if (y >= h) y = h - 1;
         end
         t[0] = texel_at(addr_of(x, y));
         for (int k = 0; k < 4; k++) ch[k] = t[0][8*k +: 8];
      end
      if (modulate) begin
         prod = ch[3] * alpha_k;
         ch[3] = has_alpha ? prod[15:8] : alpha_k;
      end
      // ch: 0 blue, 1 green, 2 red, 3 alpha
      return {ch[3], ch[0], ch[1], ch[2]};
   endfunction

   assign pending = pixel_q.size();

   always @(posedge clock) begin
      logic [31:0] want;
      int          bad;
      bad = 0;
      if (reset) begin
         tex_w <= 9'd256; tex_h <= 9'd256; edge_sel <= tsb_pkg::EDGE_CLAMP;
         linear <= 1'b0; has_alpha <= 1'b1; modulate <= 1'b0; alpha_k <= 8'd255;
         errors <= 0;
         pixel_q.delete();
      end else begin
         if (csr_we) begin
            case (csr_addr)
               tsb_pkg::REG_TEX_WIDTH:      tex_w <= csr_wdata;
               tsb_pkg::REG_TEX_HEIGHT:     tex_h <= csr_wdata;
               tsb_pkg::REG_EDGE_MODE:      edge_sel <= csr_wdata[1:0];
               tsb_pkg::REG_FILTER_LINEAR:  linear <= csr_wdata[0];
               tsb_pkg::REG_SOURCE_ALPHA:   has_alpha <= csr_wdata[0];
               tsb_pkg::REG_ALPHA_MODULATE: modulate <= csr_wdata[0];
               tsb_pkg::REG_CONST_ALPHA:    alpha_k <= csr_wdata[7:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            if (req_tuser == tsb_pkg::FUNC_LOAD) texels[req_tdata[15:0]] = req_tdata[47:16];
            else pixel_q.push_back(sample_pixel(req_tdata[79:48], req_tdata[111:80]));
         end
         if (rsp_tvalid && rsp_tready) begin
            if (pixel_q.size() == 0) begin
               $error("unexpected rsp beat %h", rsp_tdata);
               bad++;
            end else begin
               want = pixel_q.pop_front();
               if (want[7:0] !== rsp_tdata[7:0]) begin
                  $error("red: expected %h actual %h", want[7:0], rsp_tdata[7:0]);
                  bad++;
               end
               if (want[15:8] !== rsp_tdata[15:8]) begin
                  $error("green: expected %h actual %h", want[15:8], rsp_tdata[15:8]);
                  bad++;
               end
               if (want[23:16] !== rsp_tdata[23:16]) begin
                  $error("blue: expected %h actual %h", want[23:16], rsp_tdata[23:16]);
                  bad++;
               end
               if (want[31:24] !== rsp_tdata[31:24]) begin
                  $error("alpha: expected %h actual %h", want[31:24], rsp_tdata[31:24]);
                  bad++;
               end
            end
         end
         errors <= errors + bad;
      end
   end

endmodule
`default_nettype wire

/* bench/tb_top.sv */
// Testbench top for the texture sampler: stimulus, idling phases and verdict.
`timescale 1ns / 1ps
`default_nettype none
module tb_top;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [111:0] req_tdata = '0;
   logic         req_tuser = 1'b0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [31:0]  rsp_tdata;
   logic         csr_we = 1'b0;
   logic [2:0]   csr_addr = '0;
   logic [8:0]   csr_wdata = '0;
   int           errors, pending;
   int           send_idle = 0, recv_idle = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   texture_sampler_bilinear_edge dut (.*);

   tsb_checker chk (.*);

   always @(posedge clock) rsp_tready <= ($urandom_range(99) >= recv_idle);

   initial begin
      #20ms;
      $display("FAIL");
      $finish;
   end

   task automatic send_beat(logic func, logic [15:0] addr, logic [31:0] data,
                            logic [31:0] px, logic [31:0] py);
      if ($urandom_range(99) < send_idle) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < send_idle) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= func;
      req_tdata  <= {py, px, data, addr};
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic sample_at(logic [31:0] px, logic [31:0] py);
      send_beat(tsb_pkg::FUNC_SAMPLE, 16'($urandom), $urandom, px, py);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   // all registers written back to back while idle
   task automatic set_regs(logic [8:0] w, logic [8:0] h, logic [1:0] em, logic lin,
                           logic ha, logic am, logic [7:0] ka);
      logic [8:0] v [7];
      v = '{w, h, 9'(em), 9'(lin), 9'(ha), 9'(am), 9'(ka)};
      for (int i = 0; i < 7; i++) begin
         csr_we    <= 1'b1;
         csr_addr  <= 3'(i);
         csr_wdata <= v[i];
         @(posedge clock);
      end
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [31:0] rand_pos();
      case ($urandom_range(3))
         0: return $urandom;
         1: return {16'($signed($urandom_range(1200)) - 16'sd600), 16'($urandom)};
         2: return {16'($urandom_range(300)), 16'($urandom)};
         default: return {16'($signed($urandom_range(20)) - 16'sd4), 16'($urandom)};
      endcase
   endfunction

   function automatic logic [8:0] rand_size();
      case ($urandom_range(5))
         0: return 9'd0;
         1: return 9'd1;
         2: return 9'd256;
         3: return 9'($urandom);
         4: return 9'(1 << $urandom_range(8));
         default: return 9'($urandom_range(1, 40));
      endcase
   endfunction

   initial begin
      logic [31:0] edges [6];
      edges = '{32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000, 32'hffff_ffff,
                32'h00ff_ff00, 32'h0100_8000};
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // fill the whole store so no sample reads an unwritten entry
      for (int a = 0; a < 65536; a++)
         send_beat(tsb_pkg::FUNC_LOAD, 16'(a),
                   (a == 0) ? 32'h0 : (a == 65535) ? 32'hffff_ffff : $urandom,
                   $urandom, $urandom);
      drain();

      // directed: extreme positions under reset config, then two linear variants and a nearest repeat variant
      for (int i = 0; i < 6; i++) sample_at(edges[i], edges[5 - i]);
      drain();
      set_regs(9'd256, 9'd256, tsb_pkg::EDGE_UNCHECKED, 1'b1, 1'b0, 1'b1, 8'd0);
      for (int i = 0; i < 6; i++) sample_at(edges[i], edges[(i + 2) % 6]);
      drain();
      set_regs(9'd0, 9'd511, 2'd3, 1'b1, 1'b1, 1'b1, 8'd255);
      for (int i = 0; i < 6; i++) sample_at(edges[i], edges[(i + 3) % 6]);
      drain();
      set_regs(9'd7, 9'd5, tsb_pkg::EDGE_REPEAT, 1'b0, 1'b1, 1'b1, 8'd128);
      for (int i = 0; i < 6; i++) sample_at(edges[(i + 1) % 6], edges[i]);
      drain();

      for (int ph = 0; ph < 16; ph++) begin
         case (ph % 4)
            0: begin send_idle = 0;  recv_idle = 0;  end
            1: begin send_idle = 88; recv_idle = 0;  end
            2: begin send_idle = 0;  recv_idle = 88; end
            default: begin send_idle = 11; recv_idle = 11; end
         endcase
         set_regs(rand_size(), rand_size(), 2'($urandom), 1'($urandom), 1'($urandom),
                  1'($urandom), 8'($urandom));
         for (int n = 0; n < 95; n++) begin
            if ($urandom_range(9) == 0)
               send_beat(tsb_pkg::FUNC_LOAD, 16'($urandom), $urandom, $urandom, $urandom);
            else
               sample_at(rand_pos(), rand_pos());
         end
         drain();
      end

      if (errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
`default_nettype wire
